[hw/rtl/pkcs1pad_pkg.sv]
// shared types and constants for the pkcs1 v1.5 signature padding block
`default_nettype none
package pkcs1pad_pkg;

  // request function codes
  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_EMIT    = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_TOO_SHORT = 2'd1;
  localparam logic [1:0] STATUS_MISMATCH  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_EM_LENGTH      = 3'd0;
  localparam logic [2:0] REG_DIGEST_LENGTH  = 3'd1;
  localparam logic [2:0] REG_USE_OID        = 3'd2;
  localparam logic [2:0] REG_OID_LENGTH     = 3'd3;
  localparam logic [2:0] REG_OID_BYTES_LOW  = 3'd4;
  localparam logic [2:0] REG_OID_BYTES_HIGH = 3'd5;
  localparam logic [2:0] REG_VERIFY_MODE    = 3'd6;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  // register reset values
  localparam logic [9:0] EM_LENGTH_RESET     = 10'd256;
  localparam logic [6:0] DIGEST_LENGTH_RESET = 7'd36;

  // fixed bytes of the encoding
  localparam logic [7:0] BYTE_ZERO     = 8'h00;
  localparam logic [7:0] BYTE_BT       = 8'h01;
  localparam logic [7:0] BYTE_PAD      = 8'hff;
  localparam logic [7:0] BYTE_SEQ      = 8'h30;
  localparam logic [7:0] BYTE_NULL     = 8'h05;
  localparam logic [7:0] BYTE_OCTSTR   = 8'h04;

  // padding overhead: 00 01 at least eight ff, 00
  localparam int PAD_OVERHEAD = 11;
  // DigestInfo overhead around oid and digest
  localparam int DI_OVERHEAD  = 8;
  // header bytes before the oid: 30 L 30 L
  localparam int DI_HEADER    = 4;
  // outer sequence length beyond oid and digest
  localparam int DI_OUTER_ADD = 6;
  // inner sequence length beyond oid: 05 00
  localparam int DI_INNER_ADD = 2;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] em_byte;
    logic       last_byte;
    logic [1:0] status;
  } rsp_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic emit;
    logic restart;
    logic finish;
  } cmd_t;

endpackage
`default_nettype wire

[hw/rtl/pkcs1pad_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none
module pkcs1pad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

[hw/rtl/pkcs1pad_ctrl.sv]
// controller state machine: request intake, digest fetch, result hold
`default_nettype none
module pkcs1pad_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  input  wire logic [1:0]          req_func,
  output logic                     req_stall,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output pkcs1pad_pkg::cmd_t       cmd
);
  import pkcs1pad_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_FETCH  = 2'd1;
  localparam logic [1:0] ST_RESULT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       take;

  assign req_stall = (state != ST_IDLE);
  assign rsp_valid = (state == ST_RESULT);
  assign take      = req_valid && (state == ST_IDLE);

  always_comb begin
    cmd.load    = take && (req_func == FUNC_LOAD);
    cmd.emit    = take && (req_func == FUNC_EMIT);
    cmd.restart = take && (req_func == FUNC_RESTART);
    cmd.finish  = (state == ST_FETCH);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.emit) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (!rsp_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/pkcs1pad_datapath.sv]
// datapath: config registers, digest store, byte selection, verify compare
`default_nettype none
module pkcs1pad_datapath #(
  parameter int MAX_DIGEST_BYTES = 64,
  parameter int MAX_EM_BYTES     = 512,
  parameter int MAX_OID_BYTES    = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire pkcs1pad_pkg::cmd_t                     cmd,
  input  wire pkcs1pad_pkg::req_t                     req,
  input  wire logic                                   cfg_write_enable,
  input  wire logic [pkcs1pad_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [pkcs1pad_pkg::CFG_DATA_W-1:0]    cfg_data,
  output pkcs1pad_pkg::rsp_t                          rsp
);
  import pkcs1pad_pkg::*;

  localparam int ADDR_W = $clog2(MAX_DIGEST_BYTES);
  localparam int LI_W   = $clog2(MAX_DIGEST_BYTES + 1);
  localparam int EM_W   = $clog2(MAX_EM_BYTES + 1);
  // work width: holds the 10-bit register, the clamp limit and position plus one
  localparam int WK     = (EM_W > 10) ? EM_W + 1 : 11;

  // configuration
  logic [9:0]  em_length;
  logic [6:0]  digest_length;
  logic        use_oid;
  logic [4:0]  oid_length;
  logic [63:0] oid_bytes_low;
  logic [63:0] oid_bytes_high;
  logic        verify_mode;

  // block state
  logic [LI_W-1:0] load_index;
  logic [9:0]      out_position;
  logic            mismatch_flag;

  // registered decode of the byte being emitted
  logic [7:0] sel_const;
  logic       sel_digest;
  logic       sel_last;
  logic       sel_short;
  logic [7:0] sel_data;

  logic [7:0] rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      em_length      <= EM_LENGTH_RESET;
      digest_length  <= DIGEST_LENGTH_RESET;
      use_oid        <= 1'b0;
      oid_length     <= 5'd0;
      oid_bytes_low  <= 64'd0;
      oid_bytes_high <= 64'd0;
      verify_mode    <= 1'b0;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        REG_EM_LENGTH:      em_length      <= cfg_data[9:0];
        REG_DIGEST_LENGTH:  digest_length  <= cfg_data[6:0];
        REG_USE_OID:        use_oid        <= cfg_data[0];
        REG_OID_LENGTH:     oid_length     <= cfg_data[4:0];
        REG_OID_BYTES_LOW:  oid_bytes_low  <= cfg_data;
        REG_OID_BYTES_HIGH: oid_bytes_high <= cfg_data;
        REG_VERIFY_MODE:    verify_mode    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // clamped lengths
  logic [WK-1:0] em_len;
  logic [6:0]    dlen;
  logic [4:0]    olen;
  logic [WK-1:0] tlen;
  logic          too_short;
  logic [WK-1:0] pos_w;
  logic [WK-1:0] pos_inc;
  logic          last;
  logic [WK-1:0] t_start;
  logic [WK-1:0] k;
  logic [WK-1:0] j;
  logic [WK-1:0] dig_idx;
  logic [WK-1:0] oid_end;
  logic [WK-1:0] oid_off;
  logic [127:0]  oid_all;
  logic [7:0]    oid_sel;
  logic [7:0]    byte_const;
  logic          byte_digest;
  logic [ADDR_W-1:0] rd_addr;

  always_comb begin
    em_len  = (WK'(em_length) > WK'(MAX_EM_BYTES)) ? WK'(MAX_EM_BYTES) : WK'(em_length);
    dlen    = (digest_length > 7'(MAX_DIGEST_BYTES)) ? 7'(MAX_DIGEST_BYTES) : digest_length;
    olen    = (oid_length > 5'(MAX_OID_BYTES)) ? 5'(MAX_OID_BYTES) : oid_length;
    tlen    = use_oid ? (WK'(olen) + WK'(dlen) + WK'(DI_OVERHEAD)) : WK'(dlen);
    too_short = em_len < (tlen + WK'(PAD_OVERHEAD));
    pos_w   = WK'(out_position);
    pos_inc = pos_w + WK'(1);
    last    = pos_inc >= em_len;
    t_start = em_len - tlen;
    k       = pos_w - t_start;
    oid_end = WK'(DI_HEADER) + WK'(olen);
    oid_off = k - WK'(DI_HEADER);
    j       = k - oid_end;
    dig_idx = use_oid ? (j - WK'(DI_HEADER)) : k;
    oid_all = {oid_bytes_high, oid_bytes_low};
    oid_sel = oid_all[{oid_off[3:0], 3'b000} +: 8];

    byte_const  = BYTE_ZERO;
    byte_digest = 1'b0;
    rd_addr     = dig_idx[ADDR_W-1:0];
    // digest entries past the end of the store read as zero
    if (too_short) begin
      byte_const = BYTE_ZERO;
    end else if (pos_w == WK'(0)) begin
      byte_const = BYTE_ZERO;
    end else if (pos_w == WK'(1)) begin
      byte_const = BYTE_BT;
    end else if (pos_inc < t_start) begin
      byte_const = BYTE_PAD;
    end else if (pos_inc == t_start) begin
      byte_const = BYTE_ZERO;
    end else if (!use_oid) begin
      byte_digest = (dig_idx < WK'(MAX_DIGEST_BYTES));
    end else if ((k == WK'(0)) || (k == WK'(2))) begin
      byte_const = BYTE_SEQ;
    end else if (k == WK'(1)) begin
      byte_const = 8'(olen) + 8'(dlen) + 8'(DI_OUTER_ADD);
    end else if (k == WK'(3)) begin
      byte_const = 8'(olen) + 8'(DI_INNER_ADD);
    end else if (k < oid_end) begin
      byte_const = oid_sel;
    end else if (j == WK'(0)) begin
      byte_const = BYTE_NULL;
    end else if (j == WK'(1)) begin
      byte_const = BYTE_ZERO;
    end else if (j == WK'(2)) begin
      byte_const = BYTE_OCTSTR;
    end else if (j == WK'(3)) begin
      byte_const = 8'(dlen);
    end else begin
      byte_digest = (dig_idx < WK'(MAX_DIGEST_BYTES));
    end
  end

  pkcs1pad_ram #(
    .WIDTH (8),
    .DEPTH (MAX_DIGEST_BYTES)
  ) u_digest_store (
    .clk     (clk),
    .wr_en   (cmd.load && (load_index < LI_W'(MAX_DIGEST_BYTES))),
    .wr_addr (load_index[ADDR_W-1:0]),
    .wr_data (req.data_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // fetch state: expected byte, verify compare and status
  logic [7:0] expect_byte;
  logic       miss_now;
  logic [1:0] status_next;

  always_comb begin
    expect_byte = sel_digest ? rd_data : sel_const;
    miss_now    = !sel_short && verify_mode && (sel_data != expect_byte);
    status_next = STATUS_OK;
    if (sel_short) begin
      status_next = STATUS_TOO_SHORT;
    end else if (sel_last && verify_mode && (mismatch_flag || miss_now)) begin
      status_next = STATUS_MISMATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_index    <= '0;
      out_position  <= 10'd0;
      mismatch_flag <= 1'b0;
    end else begin
      if (cmd.restart) begin
        load_index    <= '0;
        out_position  <= 10'd0;
        mismatch_flag <= 1'b0;
      end
      if (cmd.load && (load_index < LI_W'(MAX_DIGEST_BYTES))) begin
        load_index <= load_index + LI_W'(1);
      end
      if (cmd.emit) begin
        out_position <= last ? 10'd0 : pos_inc[9:0];
      end
      if (cmd.finish) begin
        if (sel_last) begin
          mismatch_flag <= 1'b0;
        end else if (miss_now) begin
          mismatch_flag <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sel_const  <= byte_const;
      sel_digest <= byte_digest && !too_short;
      sel_last   <= last;
      sel_short  <= too_short;
      sel_data   <= req.data_byte;
    end
    if (cmd.finish) begin
      rsp.em_byte   <= expect_byte;
      rsp.last_byte <= sel_last;
      rsp.status    <= status_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/pkcs1_v15_signature_padding_core.sv]
// top level of the emsa pkcs1 v1.5 encoder and checker
// usage:
// - configure the registers over the write port while the block is idle
// - load the digest with func load, one byte per request transfer
// - each func emit transfer returns one response: the expected byte of
//   00 01 ff..ff 00 T at the current position, a last flag and a status
// - in verify mode the request byte is compared; a mismatch shows as
//   status on the last byte; too short lengths flag every byte
// - func restart rewinds load and output positions, keeps the digest
// timing:
// - load, restart and unused codes do not stall and return nothing
// - an emit goes through the fetch state (digest store read is registered)
//   to the result state; the response then holds until it transfers
// - no new request is taken until the previous response has transferred,
//   held up by the digest store fetch state and the held result register
// - req_stall stays high while a response waits; rsp stays stable under stall
// reset: synchronous rst restores register defaults and clears positions;
// the digest store is not cleared
`default_nettype none
module pkcs1_v15_signature_padding_core #(
  parameter int MAX_DIGEST_BYTES = 64,
  parameter int MAX_EM_BYTES     = 512,
  parameter int MAX_OID_BYTES    = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // request channel
  input  wire logic                                 req_valid,
  output logic                                      req_stall,
  input  wire pkcs1pad_pkg::req_t                   req,
  // response channel
  output logic                                      rsp_valid,
  input  wire logic                                 rsp_stall,
  output pkcs1pad_pkg::rsp_t                        rsp,
  // configuration write port
  input  wire logic                                 cfg_write_enable,
  input  wire logic [pkcs1pad_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [pkcs1pad_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pkcs1pad_pkg::*;

  cmd_t cmd;

  // sequencing: intake, fetch, hold until transfer
  pkcs1pad_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_func  (req.func),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  // byte generation, digest storage and verify logic
  pkcs1pad_datapath #(
    .MAX_DIGEST_BYTES (MAX_DIGEST_BYTES),
    .MAX_EM_BYTES     (MAX_EM_BYTES),
    .MAX_OID_BYTES    (MAX_OID_BYTES)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .req              (req),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .rsp              (rsp)
  );

endmodule
`default_nettype wire

[dv/tb_pkcs1_v15_signature_padding_core.sv]
// self-checking testbench for the pkcs1 v1.5 signature padding core
`timescale 1ns / 100ps

class em_byte_scoreboard;
  localparam int DIGEST_SLOTS = 64;
  localparam int EM_SLOTS     = 512;
  localparam int OID_SLOTS    = 16;

  // register shadow
  bit [9:0]  em_len_reg;
  bit [6:0]  dig_len_reg;
  bit        oid_en;
  bit [4:0]  oid_len_reg;
  bit [63:0] oid_lo;
  bit [63:0] oid_hi;
  bit        verify_en;

  // datapath shadow
  bit [7:0]    digest_mem [DIGEST_SLOTS];
  bit          digest_written [DIGEST_SLOTS];
  int unsigned load_idx;
  int unsigned out_pos;
  bit          miscompare_pending;

  pkcs1pad_pkg::rsp_t pending_em_bytes [$];
  int errors;
  int checked;
  int n_short;
  int n_mismatch;
  int n_last;

  function new();
    em_len_reg  = pkcs1pad_pkg::EM_LENGTH_RESET;
    dig_len_reg = pkcs1pad_pkg::DIGEST_LENGTH_RESET;
  endfunction

  function void write_reg(logic [2:0] idx, logic [63:0] val);
    case (idx)
      pkcs1pad_pkg::REG_EM_LENGTH:      em_len_reg  = val[9:0];
      pkcs1pad_pkg::REG_DIGEST_LENGTH:  dig_len_reg = val[6:0];
      pkcs1pad_pkg::REG_USE_OID:        oid_en      = val[0];
      pkcs1pad_pkg::REG_OID_LENGTH:     oid_len_reg = val[4:0];
      pkcs1pad_pkg::REG_OID_BYTES_LOW:  oid_lo      = val;
      pkcs1pad_pkg::REG_OID_BYTES_HIGH: oid_hi      = val;
      pkcs1pad_pkg::REG_VERIFY_MODE:    verify_en   = val[0];
      default: ;
    endcase
  endfunction

  function int unsigned sat(int unsigned v, int unsigned hi);
    return (v > hi) ? hi : v;
  endfunction

  function int unsigned em_bytes();
    return sat(em_len_reg, EM_SLOTS);
  endfunction

  function int unsigned digest_bytes();
    return sat(dig_len_reg, DIGEST_SLOTS);
  endfunction

  // length of T for a given register setting
  function int unsigned t_length(bit [6:0] dl, bit en, bit [4:0] ol);
    int unsigned d;
    int unsigned o;
    d = sat(dl, DIGEST_SLOTS);
    o = sat(ol, OID_SLOTS);
    return en ? o + d + pkcs1pad_pkg::DI_OVERHEAD : d;
  endfunction

  function bit short_now();
    return em_bytes() < t_length(dig_len_reg, oid_en, oid_len_reg) + pkcs1pad_pkg::PAD_OVERHEAD;
  endfunction

  // digest index sent at pos, or -1 when pos is not in the digest part
  function int digest_slot(int unsigned pos);
    int unsigned ts;
    int unsigned k;
    int unsigned ol;
    if (short_now()) return -1;
    ts = em_bytes() - t_length(dig_len_reg, oid_en, oid_len_reg);
    ol = sat(oid_len_reg, OID_SLOTS);
    if (pos < 2 || pos + 1 <= ts) return -1;
    k = pos - ts;
    if (!oid_en) return k;
    if (k < ol + pkcs1pad_pkg::DI_OVERHEAD) return -1;
    return k - ol - pkcs1pad_pkg::DI_OVERHEAD;
  endfunction

  function bit would_read_unwritten();
    int slot;
    slot = digest_slot(out_pos);
    return slot >= 0 && slot < DIGEST_SLOTS && !digest_written[slot];
  endfunction

  function bit [7:0] em_byte_at(int unsigned pos);
    int unsigned ts;
    int unsigned k;
    int unsigned ol;
    int unsigned dl;
    int          slot;
    bit [127:0]  oid_all;
    if (short_now()) return pkcs1pad_pkg::BYTE_ZERO;
    ts = em_bytes() - t_length(dig_len_reg, oid_en, oid_len_reg);
    ol = sat(oid_len_reg, OID_SLOTS);
    dl = digest_bytes();
    oid_all = {oid_hi, oid_lo};
    if (pos == 0) return pkcs1pad_pkg::BYTE_ZERO;
    if (pos == 1) return pkcs1pad_pkg::BYTE_BT;
    if (pos + 1 < ts) return pkcs1pad_pkg::BYTE_PAD;
    if (pos + 1 == ts) return pkcs1pad_pkg::BYTE_ZERO;
    slot = digest_slot(pos);
    if (slot >= 0) return (slot < DIGEST_SLOTS) ? digest_mem[slot] : pkcs1pad_pkg::BYTE_ZERO;
    k = pos - ts;
    if (k == 0 || k == 2) return pkcs1pad_pkg::BYTE_SEQ;
    if (k == 1) return 8'(ol + dl + pkcs1pad_pkg::DI_OUTER_ADD);
    if (k == 3) return 8'(ol + pkcs1pad_pkg::DI_INNER_ADD);
    if (k < pkcs1pad_pkg::DI_HEADER + ol)
      return oid_all[8 * (k - pkcs1pad_pkg::DI_HEADER) +: 8];
    k = k - pkcs1pad_pkg::DI_HEADER - ol;
    if (k == 0) return pkcs1pad_pkg::BYTE_NULL;
    if (k == 1) return pkcs1pad_pkg::BYTE_ZERO;
    if (k == 2) return pkcs1pad_pkg::BYTE_OCTSTR;
    return 8'(dl);
  endfunction

  // applies one accepted request; returns 0 when the block ignores it
  function bit take_request(pkcs1pad_pkg::req_t r);
    pkcs1pad_pkg::rsp_t e;
    bit last;
    case (r.func)
      pkcs1pad_pkg::FUNC_LOAD: begin
        if (load_idx >= DIGEST_SLOTS) return 0;
        digest_mem[load_idx]     = r.data_byte;
        digest_written[load_idx] = 1'b1;
        load_idx++;
        return 1;
      end
      pkcs1pad_pkg::FUNC_RESTART: begin
        load_idx           = 0;
        out_pos            = 0;
        miscompare_pending = 1'b0;
        return 1;
      end
      pkcs1pad_pkg::FUNC_EMIT: begin
        last       = out_pos + 1 >= em_bytes();
        e.em_byte  = em_byte_at(out_pos);
        e.last_byte = last;
        e.status   = pkcs1pad_pkg::STATUS_OK;
        if (short_now()) begin
          e.status = pkcs1pad_pkg::STATUS_TOO_SHORT;
        end else begin
          if (verify_en && r.data_byte != e.em_byte) miscompare_pending = 1'b1;
          if (last && verify_en && miscompare_pending) e.status = pkcs1pad_pkg::STATUS_MISMATCH;
        end
        if (last) begin
          out_pos            = 0;
          miscompare_pending = 1'b0;
        end else begin
          out_pos++;
        end
        pending_em_bytes.push_back(e);
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  function void check_em_byte(pkcs1pad_pkg::rsp_t got);
    pkcs1pad_pkg::rsp_t want;
    if (pending_em_bytes.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected response: byte %h last %b status %0d",
                 got.em_byte, got.last_byte, got.status);
      return;
    end
    want = pending_em_bytes.pop_front();
    checked++;
    if (want.status == pkcs1pad_pkg::STATUS_TOO_SHORT) n_short++;
    if (want.status == pkcs1pad_pkg::STATUS_MISMATCH) n_mismatch++;
    if (want.last_byte) n_last++;
    if (got.em_byte !== want.em_byte || got.last_byte !== want.last_byte ||
        got.status !== want.status) begin
      errors++;
      if (errors <= 10)
        $display("response %0d: expected byte %h last %b status %0d, got byte %h last %b status %0d",
                 checked, want.em_byte, want.last_byte, want.status,
                 got.em_byte, got.last_byte, got.status);
    end
  endfunction
endclass

module tb_pkcs1_v15_signature_padding_core;
  import pkcs1pad_pkg::*;

  localparam int ITEM_TARGET     = 1550;
  localparam int QUIET_LIMIT     = 2000;  // cycles without any transfer
  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_OFF_CYCLES = 250;
  localparam int LONG_MSG_CAP    = 130;   // longer messages are cut short
  localparam int EM_MAX          = 512;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic                   clk;
  logic                   rst;
  logic                   req_valid;
  logic                   req_stall;
  req_t                   req;
  logic                   rsp_valid;
  logic                   rsp_stall;
  rsp_t                   rsp;
  logic                   cfg_write_enable;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  em_byte_scoreboard sb = new();

  logic [63:0] reg_image [7];  // next register setting, indexed by register
  int sent_items;              // requests the block acted on
  int cfg_writes;
  bit no_gaps;                 // both sides run without idle cycles
  bit hold_off_req;            // asks the response side for a long stall
  bit allow_long;              // one long message may run to its end

  pkcs1_v15_signature_padding_core dut (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .req              (req),
    .rsp_valid        (rsp_valid),
    .rsp_stall        (rsp_stall),
    .rsp              (rsp),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // response side: checks every transfer, then stalls a random number of cycles
  initial begin : response_side
    int stall_left;
    stall_left = 0;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      // values seen here are the ones from before this edge
      if (!rst && rsp_valid && !rsp_stall) begin
        sb.check_em_byte(rsp);
        stall_left = no_gaps ? 0 : $urandom_range(0, 19);
      end
      // long hold-off so the block backs up into the request side
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        rsp_stall <= 1'b1;
        stall_left--;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // watchdog: ends the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_write_enable)
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
    $display("tb_pkcs1_v15_signature_padding_core: done, errors");
    $finish;
  end

  // one request transfer; an emit that would read a never loaded digest
  // entry becomes a load of the next entry, so that entry fills sooner or later
  task automatic send(logic [1:0] f, logic [7:0] d);
    req_t item;
    int   gap;
    item.func      = f;
    item.data_byte = d;
    if (f == FUNC_EMIT && sb.would_read_unwritten()) item.func = FUNC_LOAD;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (req_stall);
    if (sb.take_request(item)) sent_items++;
  endtask

  // drop valid and wait until every response is back and the pipe is empty
  task automatic settle();
    req_valid <= 1'b0;
    while (sb.pending_em_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // writes all registers from reg_image on back-to-back cycles
  task automatic program_regs();
    cfg_write_enable <= 1'b1;
    for (int i = REG_EM_LENGTH; i <= REG_VERIFY_MODE; i++) begin
      cfg_index <= 3'(i);
      cfg_data  <= reg_image[i];
      @(posedge clk);
      sb.write_reg(3'(i), reg_image[i]);
      cfg_writes++;
    end
    cfg_write_enable <= 1'b0;
  endtask

  // random setting; em length mostly just above the minimum for T
  task automatic choose_setting();
    int          pick;
    int unsigned tl;
    pick = $urandom_range(0, 99);
    reg_image[REG_DIGEST_LENGTH] = (pick < 8)  ? $urandom_range(64, 127) :
                                   (pick < 14) ? 0 : $urandom_range(1, 32);
    reg_image[REG_USE_OID]     = $urandom_range(0, 1);
    reg_image[REG_VERIFY_MODE] = $urandom_range(0, 1);
    reg_image[REG_OID_LENGTH]  = ($urandom_range(0, 99) < 10) ? $urandom_range(17, 31)
                                                              : $urandom_range(0, 16);
    pick = $urandom_range(0, 9);
    reg_image[REG_OID_BYTES_LOW]  = (pick == 0) ? '1 : (pick == 1) ? '0 : {$urandom, $urandom};
    reg_image[REG_OID_BYTES_HIGH] = (pick == 2) ? '1 : (pick == 3) ? '0 : {$urandom, $urandom};
    tl = sb.t_length(reg_image[REG_DIGEST_LENGTH][6:0], reg_image[REG_USE_OID][0],
                     reg_image[REG_OID_LENGTH][4:0]);
    pick = $urandom_range(0, 99);
    if (pick < 12)
      reg_image[REG_EM_LENGTH] = $urandom_range(0, tl + PAD_OVERHEAD - 1);
    else if (pick < 16)
      reg_image[REG_EM_LENGTH] = $urandom_range(EM_MAX + 1, 1023);
    else
      reg_image[REG_EM_LENGTH] = tl + PAD_OVERHEAD + $urandom_range(0, 20);
  endtask

  // restart, digest load, then the message; in verify mode the received
  // bytes are right except for an occasional corrupted one
  task automatic well_formed_message();
    int unsigned emlen;
    int unsigned count;
    int          bad_pos;
    logic [7:0]  d;
    send(FUNC_RESTART, 8'($urandom));
    // a full digest sometimes gets a few extra loads past the end of the store
    repeat (sb.digest_bytes() + ((sb.digest_bytes() == 64) ? $urandom_range(0, 2) : 0))
      send(FUNC_LOAD, 8'($urandom));
    emlen = sb.em_bytes();
    if (emlen == 0) begin
      count = 1;
    end else if (emlen > LONG_MSG_CAP && !allow_long) begin
      count = $urandom_range(20, 60);
    end else begin
      count      = emlen;
      allow_long = 1'b0;
    end
    bad_pos = ($urandom_range(0, 99) < 35) ? $urandom_range(0, count - 1) : -1;
    for (int i = 0; i < count; i++) begin
      d = sb.verify_en ? sb.em_byte_at(sb.out_pos) : 8'($urandom);
      if (i == bad_pos) d = d ^ 8'($urandom_range(1, 255));
      send(FUNC_EMIT, d);
    end
  endtask

  // unordered mix of all functions
  task automatic noise_burst();
    int pick;
    repeat ($urandom_range(5, 30)) begin
      pick = $urandom_range(0, 99);
      send((pick < 45) ? FUNC_EMIT : (pick < 75) ? FUNC_LOAD :
           (pick < 90) ? FUNC_RESTART : FUNC_UNUSED, 8'($urandom));
    end
  endtask

  initial begin : stimulus
    rst              <= 1'b1;
    req_valid        <= 1'b0;
    req              <= '0;
    cfg_write_enable <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: shortest legal message with a raw three byte digest
    reg_image[REG_EM_LENGTH]      = 14;
    reg_image[REG_DIGEST_LENGTH]  = 3;
    reg_image[REG_USE_OID]        = 0;
    reg_image[REG_OID_LENGTH]     = 0;
    reg_image[REG_OID_BYTES_LOW]  = '0;
    reg_image[REG_OID_BYTES_HIGH] = '0;
    reg_image[REG_VERIFY_MODE]    = 0;
    program_regs();
    send(FUNC_RESTART, 8'h00);
    send(FUNC_LOAD, 8'h00);
    send(FUNC_LOAD, 8'hff);
    send(FUNC_LOAD, 8'h5a);
    repeat (14) send(FUNC_EMIT, 8'($urandom));

    // zero length message: too short and last on the first byte; unused func
    settle();
    reg_image[REG_EM_LENGTH] = 0;
    program_regs();
    send(FUNC_EMIT, 8'hff);
    send(FUNC_UNUSED, 8'hff);

    // every length register beyond its limit, verify on, wrong second byte, restart
    settle();
    reg_image[REG_EM_LENGTH]      = 10'h3ff;
    reg_image[REG_DIGEST_LENGTH]  = 7'h7f;
    reg_image[REG_USE_OID]        = 1;
    reg_image[REG_OID_LENGTH]     = 5'h1f;
    reg_image[REG_OID_BYTES_LOW]  = '1;
    reg_image[REG_OID_BYTES_HIGH] = '1;
    reg_image[REG_VERIFY_MODE]    = 1;
    program_regs();
    send(FUNC_EMIT, BYTE_ZERO);
    send(FUNC_EMIT, BYTE_ZERO);
    send(FUNC_RESTART, 8'hff);

    // random phases: new setting each time, mostly well-formed messages
    for (int phase = 0; sent_items < ITEM_TARGET; phase++) begin
      settle();
      choose_setting();
      // one full message at the largest length
      allow_long = (phase == 1);
      if (phase == 1) reg_image[REG_EM_LENGTH] = EM_MAX;
      no_gaps = (phase % 5 == 4) || (phase == 3);
      program_regs();
      if (phase == 3) hold_off_req = 1'b1;
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 99) < 80) well_formed_message();
        else noise_burst();
      end
    end

    settle();
    $display("covered %0d requests and %0d checked responses over %0d register writes",
             sent_items, sb.checked, cfg_writes);
    $display("responses: %0d too short, %0d verify mismatch, %0d message ends",
             sb.n_short, sb.n_mismatch, sb.n_last);
    if (sb.errors == 0)
      $display("tb_pkcs1_v15_signature_padding_core: done, clean");
    else
      $display("tb_pkcs1_v15_signature_padding_core: done, errors");
    $finish;
  end
endmodule
